// File: rtl/bie_pkg.sv
// ----------------------------------------------------------------------------
// bie_pkg
// Shared types, opcodes and constants of the bytecode instruction executor.
// ----------------------------------------------------------------------------
package bie_pkg;

   localparam int GENERAL_REGS_DEF = 16;
   localparam int MEM_DEPTH_DEF    = 65536;

   localparam int DATA_W      = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int STATUS_W    = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_BASE   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_LENGTH = 8'd1;

   localparam int SPECIAL_COUNT = 9;
   localparam int SP_BASE  = 0;
   localparam int SP_IP    = 1;
   localparam int SP_LEN   = 2;
   localparam int SP_ADDR  = 6;
   localparam int SP_SYS   = 7;
   localparam int SP_FLAGS = 8;

   localparam logic [DATA_W-1:0] FLAG_LESS    = 32'h0000_0001;
   localparam logic [DATA_W-1:0] FLAG_EQUAL   = 32'h0000_0002;
   localparam logic [DATA_W-1:0] FLAG_GREATER = 32'h0000_0004;

   localparam logic [DATA_W-1:0] SVC_EXIT_NUM = 32'd1;
   localparam logic [DATA_W-1:0] SYS_EXIT     = 32'd1;
   localparam logic [DATA_W-1:0] SYS_ABORT    = 32'd2;

   localparam logic [STATUS_W-1:0] STAT_RUN     = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_END     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_DIV0    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_INVALID = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_ABORT   = 3'd4;

   localparam logic [7:0] OP_NOP      = 8'h00;
   localparam logic [7:0] OP_LDI      = 8'h01;
   localparam logic [7:0] OP_MOV      = 8'h02;
   localparam logic [7:0] OP_STI      = 8'h03;
   localparam logic [7:0] OP_ST       = 8'h04;
   localparam logic [7:0] OP_LD       = 8'h05;
   localparam logic [7:0] OP_SVCI     = 8'h06;
   localparam logic [7:0] OP_SVC      = 8'h07;
   localparam logic [7:0] OP_JEQ_IMM  = 8'h08;
   localparam logic [7:0] OP_JEQ_REG  = 8'h09;
   localparam logic [7:0] OP_JEQR_IMM = 8'h0A;
   localparam logic [7:0] OP_JEQR_REG = 8'h0B;
   localparam logic [7:0] OP_JNE_IMM  = 8'h0C;
   localparam logic [7:0] OP_JNE_REG  = 8'h0D;
   localparam logic [7:0] OP_JNER_IMM = 8'h0E;
   localparam logic [7:0] OP_JNER_REG = 8'h0F;
   localparam logic [7:0] OP_ADDI     = 8'h10;
   localparam logic [7:0] OP_ADD      = 8'h11;
   localparam logic [7:0] OP_SUBI     = 8'h12;
   localparam logic [7:0] OP_SUB      = 8'h13;
   localparam logic [7:0] OP_MULI     = 8'h14;
   localparam logic [7:0] OP_MUL      = 8'h15;
   localparam logic [7:0] OP_DIVI     = 8'h16;
   localparam logic [7:0] OP_DIV      = 8'h17;
   localparam logic [7:0] OP_ANDI     = 8'h18;
   localparam logic [7:0] OP_AND      = 8'h19;
   localparam logic [7:0] OP_ORI      = 8'h1A;
   localparam logic [7:0] OP_OR       = 8'h1B;
   localparam logic [7:0] OP_XORI     = 8'h1C;
   localparam logic [7:0] OP_XOR      = 8'h1D;
   localparam logic [7:0] OP_SHLI     = 8'h1E;
   localparam logic [7:0] OP_SHL      = 8'h1F;
   localparam logic [7:0] OP_SHRI     = 8'h20;
   localparam logic [7:0] OP_SHR      = 8'h21;
   localparam logic [7:0] OP_NOT      = 8'h22;
   localparam logic [7:0] OP_CMPI     = 8'h23;
   localparam logic [7:0] OP_CMP      = 8'h24;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_B,
      S_RD_C,
      S_RD_D,
      S_RD_R0,
      S_RD_R1,
      S_EXEC,
      S_DIV,
      S_COMMIT
   } state_type;

   typedef enum logic [2:0] {
      SEL_B,
      SEL_C,
      SEL_D,
      SEL_R0,
      SEL_R1
   } sel_type;

   typedef struct packed {
      logic    accept;
      logic    clr;
      sel_type rd_sel;
      logic    cap_en;
      sel_type cap_sel;
      logic    exec;
      logic    div_start;
      logic    commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_go;
      logic div_done;
      logic clr_done;
      logic out_free;
   } dp_stat_type;

endpackage

// File: rtl/bie_req_if.sv
// ----------------------------------------------------------------------------
// bie_req_if
// Instruction word channel: valid/ready with the four instruction bytes.
// ----------------------------------------------------------------------------
interface bie_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] opcode;
   logic [7:0] arg_b;
   logic [7:0] arg_c;
   logic [7:0] arg_d;

   modport source (output valid, output opcode, output arg_b, output arg_c,
                   output arg_d, input ready);
   modport sink   (input valid, input opcode, input arg_b, input arg_c,
                   input arg_d, output ready);
endinterface

// File: rtl/bie_rsp_if.sv
// ----------------------------------------------------------------------------
// bie_rsp_if
// Result word channel: valid/ready with pointer, status and service fields.
// ----------------------------------------------------------------------------
interface bie_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_ip;
   logic [2:0]  status;
   logic [31:0] exit_code;
   logic        service_request;
   logic [31:0] service_number;
   logic [31:0] service_selector;
   logic [31:0] service_arg0;
   logic [31:0] service_arg1;

   modport source (output valid, output next_ip, output status, output exit_code,
                   output service_request, output service_number,
                   output service_selector, output service_arg0,
                   output service_arg1, input ready);
   modport sink   (input valid, input next_ip, input status, input exit_code,
                   input service_request, input service_number,
                   input service_selector, input service_arg0,
                   input service_arg1, output ready);
endinterface

// File: rtl/bie_csr_if.sv
// ----------------------------------------------------------------------------
// bie_csr_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface bie_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/bie_ram.sv
// ----------------------------------------------------------------------------
// bie_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bie_div.sv
// ----------------------------------------------------------------------------
// bie_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bie_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [32:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/bie_ctrl.sv
// ----------------------------------------------------------------------------
// bie_ctrl
// Instruction sequencer: clear, accept, operand reads, execute, divide, commit.
// ----------------------------------------------------------------------------
module bie_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  bie_pkg::dp_stat_type  stat,
   output bie_pkg::ctrl_cmd_type cmd
);

   bie_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bie_pkg::S_CLEAR:  if (stat.clr_done) state_in = bie_pkg::S_IDLE;
         bie_pkg::S_IDLE:   if (req_valid) state_in = bie_pkg::S_RD_B;
         bie_pkg::S_RD_B:   state_in = bie_pkg::S_RD_C;
         bie_pkg::S_RD_C:   state_in = bie_pkg::S_RD_D;
         bie_pkg::S_RD_D:   state_in = bie_pkg::S_RD_R0;
         bie_pkg::S_RD_R0:  state_in = bie_pkg::S_RD_R1;
         bie_pkg::S_RD_R1:  state_in = bie_pkg::S_EXEC;
         bie_pkg::S_EXEC:   state_in = stat.div_go ? bie_pkg::S_DIV : bie_pkg::S_COMMIT;
         bie_pkg::S_DIV:    if (stat.div_done) state_in = bie_pkg::S_COMMIT;
         bie_pkg::S_COMMIT: if (stat.out_free) state_in = bie_pkg::S_IDLE;
         default:           state_in = bie_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '{accept: 1'b0, clr: 1'b0, rd_sel: bie_pkg::SEL_B, cap_en: 1'b0,
              cap_sel: bie_pkg::SEL_B, exec: 1'b0, div_start: 1'b0, commit: 1'b0};
      case (state_ff)
         bie_pkg::S_CLEAR: cmd.clr = 1'b1;
         bie_pkg::S_IDLE:  cmd.accept = 1'b1;
         bie_pkg::S_RD_B:  cmd.rd_sel = bie_pkg::SEL_B;
         bie_pkg::S_RD_C: begin
            cmd.rd_sel  = bie_pkg::SEL_C;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = bie_pkg::SEL_B;
         end
         bie_pkg::S_RD_D: begin
            cmd.rd_sel  = bie_pkg::SEL_D;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = bie_pkg::SEL_C;
         end
         bie_pkg::S_RD_R0: begin
            cmd.rd_sel  = bie_pkg::SEL_R0;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = bie_pkg::SEL_D;
         end
         bie_pkg::S_RD_R1: begin
            cmd.rd_sel  = bie_pkg::SEL_R1;
            cmd.cap_en  = 1'b1;
            cmd.cap_sel = bie_pkg::SEL_R0;
         end
         bie_pkg::S_EXEC: begin
            cmd.cap_en    = 1'b1;
            cmd.cap_sel   = bie_pkg::SEL_R1;
            cmd.exec      = 1'b1;
            cmd.div_start = stat.div_go;
         end
         bie_pkg::S_DIV:    cmd.commit = 1'b0;
         bie_pkg::S_COMMIT: cmd.commit = stat.out_free;
         default:           cmd.commit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bie_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/bie_dp.sv
// ----------------------------------------------------------------------------
// bie_dp
// Datapath: register file, special registers, data memory, ALU and result.
// ----------------------------------------------------------------------------
module bie_dp #(
   parameter int GENERAL_REGS = bie_pkg::GENERAL_REGS_DEF,
   parameter int MEM_DEPTH    = bie_pkg::MEM_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bie_pkg::ctrl_cmd_type           cmd,
   output bie_pkg::dp_stat_type            stat,
   input  logic                            req_fire,
   input  logic [7:0]                      req_opcode,
   input  logic [7:0]                      req_arg_b,
   input  logic [7:0]                      req_arg_c,
   input  logic [7:0]                      req_arg_d,
   input  logic                            csr_fire,
   input  logic [bie_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                     csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [31:0]                     rsp_next_ip,
   output logic [2:0]                      rsp_status,
   output logic [31:0]                     rsp_exit_code,
   output logic                            rsp_service_request,
   output logic [31:0]                     rsp_service_number,
   output logic [31:0]                     rsp_service_selector,
   output logic [31:0]                     rsp_service_arg0,
   output logic [31:0]                     rsp_service_arg1
);

   localparam int GW = $clog2(GENERAL_REGS);
   localparam int MW = $clog2(MEM_DEPTH);
   localparam logic [7:0] IDX_SPEC  = 8'(GENERAL_REGS);
   localparam logic [7:0] IDX_IP    = 8'(GENERAL_REGS + bie_pkg::SP_IP);
   localparam logic [7:0] IDX_FLAGS = 8'(GENERAL_REGS + bie_pkg::SP_FLAGS);

   // instruction and operands
   logic [7:0]  op_ff, b_ff, c_ff, d_ff;
   logic [31:0] opb_ff, opc_ff, opd_ff, r0_ff, r1_ff;

   // architectural state
   logic [31:0] spec_ff [bie_pkg::SPECIAL_COUNT];
   logic [31:0] spec_in [bie_pkg::SPECIAL_COUNT];
   logic [31:0] scratch_ff, scratch_in;
   logic [31:0] end_ff, end_in;
   logic [31:0] cfg_base_ff, cfg_base_in;
   logic [31:0] cfg_len_ff, cfg_len_in;
   logic [7:0]  spare_ff, spare_in;
   logic [GENERAL_REGS-1:0] gvld_ff, gvld_in;
   logic        vld_q_ff;
   logic [MW-1:0] clr_ff;

   // writeback
   logic        wb_skip_ff, wb_wr_ff, wb_fl_en_ff, wb_jmp_ff, wb_mwr_ff, wb_svc_ff;
   logic [31:0] wb_val_ff, wb_fl_ff, wb_jip_ff, wb_exit_ff, wb_snum_ff;
   logic [7:0]  wb_mval_ff;
   logic [2:0]  wb_stat_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_ip_ff, rsp_exit_ff, rsp_snum_ff, rsp_ssel_ff, rsp_a0_ff, rsp_a1_ff;
   logic [2:0]  rsp_stat_ff;
   logic        rsp_svc_ff;

   // register file and memory ports
   logic [7:0]    rd_idx, cap_idx, cap_m, b_m;
   logic [31:0]   greg_q, cap_val;
   logic          greg_we;
   logic [7:0]    mem_q, mem_wdata;
   logic          mem_we;
   logic [MW-1:0] mem_waddr;
   logic          addr_ok;

   // execute
   logic [31:0] imm16, tgt16, base, ip, fl, alu_rhs, mul_res, shl_res, shr_res;
   logic [31:0] cmp_rhs, new_fl, rb_eff, rc_eff, cond_rhs, divisor, svc_num, ld_val;
   logic        x_skip, x_wr, x_fl_en, x_jmp, x_mwr, x_svc, div_zero, is_div;
   logic [31:0] x_val, x_jip, x_exit;
   logic [7:0]  x_mval;
   logic [2:0]  x_stat;
   logic        div_done;
   logic [31:0] div_quo;

   // commit
   logic        tgt_gen, tgt_spec;
   logic [31:0] pre_ip, new_ip;
   logic [2:0]  fin_stat;

   function automatic logic [7:0] sel_idx(input bie_pkg::sel_type s, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d);
      logic [7:0] r;
      case (s)
         bie_pkg::SEL_B:  r = b;
         bie_pkg::SEL_C:  r = c;
         bie_pkg::SEL_D:  r = d;
         bie_pkg::SEL_R0: r = 8'd0;
         bie_pkg::SEL_R1: r = 8'd1;
         default:         r = b;
      endcase
      return r;
   endfunction

   bie_ram #(.WIDTH(32), .DEPTH(GENERAL_REGS)) u_greg (
      .clock (clock),
      .we    (greg_we),
      .waddr (b_ff[GW-1:0]),
      .wdata (wb_val_ff),
      .raddr (rd_idx[GW-1:0]),
      .rdata (greg_q)
   );

   bie_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_dmem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (spec_ff[bie_pkg::SP_ADDR][MW-1:0]),
      .rdata (mem_q)
   );

   bie_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (opb_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // operand read
   always_comb begin
      rd_idx  = sel_idx(cmd.rd_sel, b_ff, c_ff, d_ff);
      cap_idx = sel_idx(cmd.cap_sel, b_ff, c_ff, d_ff);
      cap_m   = cap_idx - IDX_SPEC;
      if (cap_idx < IDX_SPEC) begin
         cap_val = vld_q_ff ? greg_q : '0;
      end else if (cap_m < 8'(bie_pkg::SPECIAL_COUNT)) begin
         cap_val = spec_ff[cap_m[3:0]];
      end else begin
         cap_val = scratch_ff;
      end
   end

   // execute
   always_comb begin
      imm16    = {16'd0, c_ff, d_ff};
      tgt16    = {16'd0, b_ff, c_ff};
      base     = spec_ff[bie_pkg::SP_BASE];
      ip       = spec_ff[bie_pkg::SP_IP];
      fl       = spec_ff[bie_pkg::SP_FLAGS];
      addr_ok  = {1'b0, spec_ff[bie_pkg::SP_ADDR]} < 33'(MEM_DEPTH);
      ld_val   = {24'd0, addr_ok ? mem_q : spare_ff};
      alu_rhs  = op_ff[0] ? opc_ff : imm16;
      mul_res  = opb_ff * alu_rhs;
      shl_res  = (|alu_rhs[31:5]) ? '0 : (opb_ff << alu_rhs[4:0]);
      shr_res  = (|alu_rhs[31:5]) ? '0 : (opb_ff >> alu_rhs[4:0]);
      cmp_rhs  = (op_ff == bie_pkg::OP_SUBI || op_ff == bie_pkg::OP_CMPI) ? imm16 : opc_ff;
      if (opb_ff < cmp_rhs) begin
         new_fl = bie_pkg::FLAG_LESS;
      end else if (opb_ff == cmp_rhs) begin
         new_fl = bie_pkg::FLAG_EQUAL;
      end else begin
         new_fl = bie_pkg::FLAG_GREATER;
      end
      rb_eff   = (b_ff == IDX_FLAGS) ? new_fl : opb_ff;
      rc_eff   = (c_ff == IDX_FLAGS) ? new_fl : opc_ff;
      case (op_ff[1:0])
         2'b00:   cond_rhs = {24'd0, d_ff};
         2'b01:   cond_rhs = opd_ff;
         2'b10:   cond_rhs = imm16;
         default: cond_rhs = opc_ff;
      endcase
      divisor  = (op_ff == bie_pkg::OP_DIVI) ? imm16 : opc_ff;
      div_zero = (divisor == '0);
      is_div   = (op_ff == bie_pkg::OP_DIVI) || (op_ff == bie_pkg::OP_DIV);
      svc_num  = (op_ff == bie_pkg::OP_SVCI) ? {8'd0, b_ff, c_ff, d_ff} : opb_ff;
      x_skip   = ip >= end_ff;
      x_wr     = 1'b0;
      x_val    = '0;
      x_fl_en  = 1'b0;
      x_jmp    = 1'b0;
      x_jip    = op_ff[1] ? (base + opb_ff) : (base + tgt16);
      x_mwr    = 1'b0;
      x_mval   = b_ff;
      x_svc    = 1'b0;
      x_exit   = '0;
      x_stat   = bie_pkg::STAT_RUN;
      case (op_ff)
         bie_pkg::OP_NOP: x_wr = 1'b0;
         bie_pkg::OP_LDI: begin x_wr = 1'b1; x_val = imm16; end
         bie_pkg::OP_MOV: begin x_wr = 1'b1; x_val = opc_ff; end
         bie_pkg::OP_STI: x_mwr = 1'b1;
         bie_pkg::OP_ST: begin x_mwr = 1'b1; x_mval = opb_ff[7:0]; end
         bie_pkg::OP_LD: begin x_wr = 1'b1; x_val = ld_val; end
         bie_pkg::OP_SVCI, bie_pkg::OP_SVC: begin
            if (svc_num == bie_pkg::SVC_EXIT_NUM
                && spec_ff[bie_pkg::SP_SYS] == bie_pkg::SYS_EXIT) begin
               x_stat = bie_pkg::STAT_END;
               x_exit = r0_ff;
            end else if (svc_num == bie_pkg::SVC_EXIT_NUM
                         && spec_ff[bie_pkg::SP_SYS] == bie_pkg::SYS_ABORT) begin
               x_stat = bie_pkg::STAT_ABORT;
            end else begin
               x_svc = 1'b1;
            end
         end
         bie_pkg::OP_JEQ_IMM, bie_pkg::OP_JEQ_REG, bie_pkg::OP_JEQR_IMM,
         bie_pkg::OP_JEQR_REG:
            x_jmp = (fl == cond_rhs);
         bie_pkg::OP_JNE_IMM, bie_pkg::OP_JNE_REG, bie_pkg::OP_JNER_IMM,
         bie_pkg::OP_JNER_REG:
            x_jmp = (fl != cond_rhs);
         bie_pkg::OP_ADDI, bie_pkg::OP_ADD: begin x_wr = 1'b1; x_val = opb_ff + alu_rhs; end
         bie_pkg::OP_SUBI: begin
            x_fl_en = 1'b1;
            x_wr    = 1'b1;
            x_val   = rb_eff - imm16;
         end
         bie_pkg::OP_SUB: begin
            x_fl_en = 1'b1;
            x_wr    = 1'b1;
            x_val   = rb_eff - rc_eff;
         end
         bie_pkg::OP_MULI, bie_pkg::OP_MUL: begin x_wr = 1'b1; x_val = mul_res; end
         bie_pkg::OP_DIVI, bie_pkg::OP_DIV: begin
            if (div_zero) begin
               x_stat = bie_pkg::STAT_DIV0;
            end else begin
               x_wr = 1'b1;
            end
         end
         bie_pkg::OP_ANDI, bie_pkg::OP_AND: begin x_wr = 1'b1; x_val = opb_ff & alu_rhs; end
         bie_pkg::OP_ORI, bie_pkg::OP_OR:   begin x_wr = 1'b1; x_val = opb_ff | alu_rhs; end
         bie_pkg::OP_XORI, bie_pkg::OP_XOR: begin x_wr = 1'b1; x_val = opb_ff ^ alu_rhs; end
         bie_pkg::OP_SHLI, bie_pkg::OP_SHL: begin x_wr = 1'b1; x_val = shl_res; end
         bie_pkg::OP_SHRI, bie_pkg::OP_SHR: begin x_wr = 1'b1; x_val = shr_res; end
         bie_pkg::OP_NOT:  begin x_wr = 1'b1; x_val = ~opb_ff; end
         bie_pkg::OP_CMPI, bie_pkg::OP_CMP: x_fl_en = 1'b1;
         default: x_stat = bie_pkg::STAT_INVALID;
      endcase
   end

   // commit
   always_comb begin
      b_m      = b_ff - IDX_SPEC;
      tgt_gen  = b_ff < IDX_SPEC;
      tgt_spec = !tgt_gen && (b_m < 8'(bie_pkg::SPECIAL_COUNT));
      if (wb_wr_ff && b_ff == IDX_IP) begin
         pre_ip = wb_val_ff;
      end else if (wb_jmp_ff) begin
         pre_ip = wb_jip_ff;
      end else begin
         pre_ip = ip;
      end
      new_ip   = pre_ip + 32'd4;
      fin_stat = (wb_stat_ff == bie_pkg::STAT_RUN && new_ip >= end_ff)
                 ? bie_pkg::STAT_END : wb_stat_ff;

      greg_we   = cmd.commit && !wb_skip_ff && wb_wr_ff && tgt_gen;
      mem_we    = cmd.clr || (cmd.commit && !wb_skip_ff && wb_mwr_ff && addr_ok);
      mem_waddr = cmd.clr ? clr_ff : spec_ff[bie_pkg::SP_ADDR][MW-1:0];
      mem_wdata = cmd.clr ? 8'd0 : wb_mval_ff;

      gvld_in    = gvld_ff;
      spec_in    = spec_ff;
      scratch_in = scratch_ff;
      spare_in   = spare_ff;
      end_in     = end_ff;
      cfg_base_in = cfg_base_ff;
      cfg_len_in  = cfg_len_ff;
      if (greg_we) begin
         gvld_in[b_ff[GW-1:0]] = 1'b1;
      end
      if (cmd.commit && !wb_skip_ff) begin
         if (wb_fl_en_ff) begin
            spec_in[bie_pkg::SP_FLAGS] = wb_fl_ff;
         end
         if (wb_wr_ff && tgt_spec) begin
            spec_in[b_m[3:0]] = wb_val_ff;
         end
         if (wb_wr_ff && !tgt_gen && !tgt_spec) begin
            scratch_in = wb_val_ff;
         end
         if (wb_mwr_ff && !addr_ok) begin
            spare_in = wb_mval_ff;
         end
         spec_in[bie_pkg::SP_IP] = new_ip;
      end
      if (csr_fire && csr_index == bie_pkg::CSR_CODE_BASE) begin
         cfg_base_in = csr_data;
      end
      if (csr_fire && csr_index == bie_pkg::CSR_CODE_LENGTH) begin
         cfg_len_in = csr_data;
      end
      if (csr_fire && (csr_index == bie_pkg::CSR_CODE_BASE
                       || csr_index == bie_pkg::CSR_CODE_LENGTH)) begin
         spec_in[bie_pkg::SP_BASE] = cfg_base_in;
         spec_in[bie_pkg::SP_IP]   = cfg_base_in;
         spec_in[bie_pkg::SP_LEN]  = cfg_len_in;
         end_in = cfg_base_in + cfg_len_in;
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bie_pkg::SPECIAL_COUNT; i++) begin
            spec_ff[i] <= '0;
         end
         scratch_ff   <= '0;
         spare_ff     <= '0;
         end_ff       <= '0;
         cfg_base_ff  <= '0;
         cfg_len_ff   <= '0;
         gvld_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         spec_ff      <= spec_in;
         scratch_ff   <= scratch_in;
         spare_ff     <= spare_in;
         end_ff       <= end_in;
         cfg_base_ff  <= cfg_base_in;
         cfg_len_ff   <= cfg_len_in;
         gvld_ff      <= gvld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clr) begin
            clr_ff <= clr_ff + MW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff <= req_opcode;
         b_ff  <= req_arg_b;
         c_ff  <= req_arg_c;
         d_ff  <= req_arg_d;
      end
      vld_q_ff <= (rd_idx < IDX_SPEC) ? gvld_ff[rd_idx[GW-1:0]] : 1'b0;
      if (cmd.cap_en) begin
         case (cmd.cap_sel)
            bie_pkg::SEL_B:  opb_ff <= cap_val;
            bie_pkg::SEL_C:  opc_ff <= cap_val;
            bie_pkg::SEL_D:  opd_ff <= cap_val;
            bie_pkg::SEL_R0: r0_ff  <= cap_val;
            bie_pkg::SEL_R1: r1_ff  <= cap_val;
            default:         opb_ff <= cap_val;
         endcase
      end
      if (cmd.exec) begin
         wb_skip_ff  <= x_skip;
         wb_wr_ff    <= x_wr;
         wb_val_ff   <= x_val;
         wb_fl_en_ff <= x_fl_en;
         wb_fl_ff    <= new_fl;
         wb_jmp_ff   <= x_jmp;
         wb_jip_ff   <= x_jip;
         wb_mwr_ff   <= x_mwr;
         wb_mval_ff  <= x_mval;
         wb_stat_ff  <= x_stat;
         wb_exit_ff  <= x_exit;
         wb_svc_ff   <= x_svc;
         wb_snum_ff  <= svc_num;
      end else if (div_done) begin
         wb_val_ff <= div_quo;
      end
      if (cmd.commit) begin
         if (wb_skip_ff) begin
            rsp_ip_ff   <= ip;
            rsp_stat_ff <= bie_pkg::STAT_END;
            rsp_exit_ff <= '0;
            rsp_svc_ff  <= 1'b0;
            rsp_snum_ff <= '0;
            rsp_ssel_ff <= '0;
            rsp_a0_ff   <= '0;
            rsp_a1_ff   <= '0;
         end else begin
            rsp_ip_ff   <= new_ip;
            rsp_stat_ff <= fin_stat;
            rsp_exit_ff <= wb_exit_ff;
            rsp_svc_ff  <= wb_svc_ff;
            rsp_snum_ff <= wb_svc_ff ? wb_snum_ff : '0;
            rsp_ssel_ff <= wb_svc_ff ? spec_ff[bie_pkg::SP_SYS] : '0;
            rsp_a0_ff   <= wb_svc_ff ? r0_ff : '0;
            rsp_a1_ff   <= wb_svc_ff ? r1_ff : '0;
         end
      end
   end

   assign stat.div_go   = !x_skip && is_div && !div_zero;
   assign stat.div_done = div_done;
   assign stat.clr_done = (clr_ff == MW'(MEM_DEPTH - 1));
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_next_ip          = rsp_ip_ff;
   assign rsp_status           = rsp_stat_ff;
   assign rsp_exit_code        = rsp_exit_ff;
   assign rsp_service_request  = rsp_svc_ff;
   assign rsp_service_number   = rsp_snum_ff;
   assign rsp_service_selector = rsp_ssel_ff;
   assign rsp_service_arg0     = rsp_a0_ff;
   assign rsp_service_arg1     = rsp_a1_ff;

endmodule

// File: rtl/bytecode_instruction_executor_unit.sv
// ----------------------------------------------------------------------------
// bytecode_instruction_executor_unit
// Executes one four-byte instruction word per request and returns one result.
//
// Channels: req_if carries the instruction word (opcode, arg_b, arg_c,
// arg_d); rsp_if returns the next pointer, status and service fields;
// csr_if writes code_base (index 0) and code_length (index 1), always ready, and
// must be written only while the unit is idle, which the unit does not enforce.
// Sequence: an accepted word passes RD_B, RD_C, RD_D, RD_R0, RD_R1, EXEC,
// DIV (for a divide by a nonzero value, unless skipped) and COMMIT; rsp_if.valid
// is registered at commit. The general registers sit in a RAM with one read
// port, read one operand per cycle, and the divider produces one quotient
// bit per cycle; a new word is accepted only after the last one commits.
// Reset: clears the architectural and configuration registers and valid bits,
// then zeroes the data memory one byte per cycle; req_if is not ready meanwhile.
// Stall: a finished result is held in the output register; the next word is
// accepted and executed, and its commit waits until rsp_if takes the held
// result.
// ----------------------------------------------------------------------------
module bytecode_instruction_executor_unit #(
   parameter int GENERAL_REGS = bie_pkg::GENERAL_REGS_DEF,
   parameter int MEM_DEPTH    = bie_pkg::MEM_DEPTH_DEF
) (
   input logic     clock,
   input logic     reset,
   bie_req_if.sink   req_if,
   bie_rsp_if.source rsp_if,
   bie_csr_if.sink   csr_if
);

   bie_pkg::ctrl_cmd_type cmd;
   bie_pkg::dp_stat_type  stat;

   assign req_if.ready = cmd.accept;
   assign csr_if.ready = 1'b1;

   bie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   bie_dp #(
      .GENERAL_REGS (GENERAL_REGS),
      .MEM_DEPTH    (MEM_DEPTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_fire             (req_if.valid && cmd.accept),
      .req_opcode           (req_if.opcode),
      .req_arg_b            (req_if.arg_b),
      .req_arg_c            (req_if.arg_c),
      .req_arg_d            (req_if.arg_d),
      .csr_fire             (csr_if.valid),
      .csr_index            (csr_if.index),
      .csr_data             (csr_if.data),
      .rsp_valid            (rsp_if.valid),
      .rsp_ready            (rsp_if.ready),
      .rsp_next_ip          (rsp_if.next_ip),
      .rsp_status           (rsp_if.status),
      .rsp_exit_code        (rsp_if.exit_code),
      .rsp_service_request  (rsp_if.service_request),
      .rsp_service_number   (rsp_if.service_number),
      .rsp_service_selector (rsp_if.service_selector),
      .rsp_service_arg0     (rsp_if.service_arg0),
      .rsp_service_arg1     (rsp_if.service_arg1)
   );

endmodule

// File: sim/tb_ifs.sv
// ----------------------------------------------------------------------------
// tb_ifs
// Bench timing constants; the channel interfaces come from the rtl folder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tb_ifs_pkg;
   localparam int TB_PERIOD_NS = 20;
endpackage

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bytecode instruction executor: a queue-fed
// driver sends instruction words, an in-bench executor model predicts each
// result, and a monitor compares every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;

   localparam int NGR  = bie_pkg::GENERAL_REGS_DEF;
   localparam int NSP  = bie_pkg::SPECIAL_COUNT;
   localparam int MEMD = bie_pkg::MEM_DEPTH_DEF;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] arg_b;
      logic [7:0] arg_c;
      logic [7:0] arg_d;
   } instr_type;

   typedef struct packed {
      logic [31:0] next_ip;
      logic [2:0]  status;
      logic [31:0] exit_code;
      logic        service_request;
      logic [31:0] service_number;
      logic [31:0] service_selector;
      logic [31:0] service_arg0;
      logic [31:0] service_arg1;
   } result_type;

   logic clock;
   logic reset;
   bie_req_if req_if ();
   bie_rsp_if rsp_if ();
   bie_csr_if csr_if ();

   bytecode_instruction_executor_unit dut (
      .clock(clock), .reset(reset),
      .req_if(req_if), .rsp_if(rsp_if), .csr_if(csr_if)
   );

   // executor shadow state
   logic [31:0] gpr [NGR];
   logic [31:0] spr [NSP];
   logic [31:0] scratch;
   logic [31:0] end_addr;
   logic [31:0] base_cfg, len_cfg;
   logic [7:0]  dmem [MEMD];
   logic [7:0]  spare;

   instr_type  instr_q [$];
   result_type result_q [$];
   int      errors = 0;
   int      n_checked = 0;
   int      n_svc = 0, n_jump = 0, n_div0 = 0;
   longint  cycles = 0;
   int      rsp_hold = 0;
   int      n_sent;
   logic    pause_send = 0;
   logic    long_hold;
   int      hold_left;
   logic    hold_used;

   initial begin
      clock = 0;
      forever #(tb_ifs_pkg::TB_PERIOD_NS / 2) clock = ~clock;
   end

   task automatic queue_word(input instr_type w);
      instr_q.insert(instr_q.size(), w);
   endtask

   task automatic queue_result(input result_type r);
      result_q.insert(result_q.size(), r);
   endtask

   function automatic logic [31:0] rd_reg(input logic [7:0] idx);
      if (idx < NGR) return gpr[idx];
      if (idx < NGR + NSP) return spr[idx - NGR];
      return scratch;
   endfunction

   task automatic wr_reg(input logic [7:0] idx, input logic [31:0] v);
      if (idx < NGR) gpr[idx] = v;
      else if (idx < NGR + NSP) spr[idx - NGR] = v;
      else scratch = v;
   endtask

   function automatic logic [31:0] cmp_flags(input logic [31:0] l, input logic [31:0] r);
      if (l < r) return bie_pkg::FLAG_LESS;
      if (l == r) return bie_pkg::FLAG_EQUAL;
      return bie_pkg::FLAG_GREATER;
   endfunction

   task automatic load_code();
      spr[bie_pkg::SP_BASE] = base_cfg;
      spr[bie_pkg::SP_IP] = base_cfg;
      spr[bie_pkg::SP_LEN] = len_cfg;
      end_addr = base_cfg + len_cfg;
   endtask

   task automatic execute_word(input instr_type w);
      result_type r;
      logic [31:0] vb, vc, vd, fl, bs, imm16, tgt16, num, addr;
      logic svc;
      r = '0;
      svc = 0;
      num = 0;
      if (spr[bie_pkg::SP_IP] >= end_addr) begin
         r.next_ip = spr[bie_pkg::SP_IP];
         r.status = bie_pkg::STAT_END;
         queue_result(r);
         return;
      end
      vb = rd_reg(w.arg_b);
      vc = rd_reg(w.arg_c);
      vd = rd_reg(w.arg_d);
      fl = spr[bie_pkg::SP_FLAGS];
      bs = spr[bie_pkg::SP_BASE];
      addr = spr[bie_pkg::SP_ADDR];
      imm16 = {16'd0, w.arg_c, w.arg_d};
      tgt16 = {16'd0, w.arg_b, w.arg_c};
      case (w.opcode)
         bie_pkg::OP_NOP: ;
         bie_pkg::OP_LDI: wr_reg(w.arg_b, imm16);
         bie_pkg::OP_MOV: wr_reg(w.arg_b, vc);
         bie_pkg::OP_STI: if (addr < MEMD) dmem[addr] = w.arg_b; else spare = w.arg_b;
         bie_pkg::OP_ST: if (addr < MEMD) dmem[addr] = vb[7:0]; else spare = vb[7:0];
         bie_pkg::OP_LD: wr_reg(w.arg_b, {24'd0, (addr < MEMD) ? dmem[addr] : spare});
         bie_pkg::OP_SVCI: begin
            num = {8'd0, w.arg_b, w.arg_c, w.arg_d};
            svc = 1;
         end
         bie_pkg::OP_SVC: begin
            num = vb;
            svc = 1;
         end
         bie_pkg::OP_JEQ_IMM: if (fl == {24'd0, w.arg_d}) spr[bie_pkg::SP_IP] = bs + tgt16;
         bie_pkg::OP_JEQ_REG: if (fl == vd) spr[bie_pkg::SP_IP] = bs + tgt16;
         bie_pkg::OP_JEQR_IMM: if (fl == imm16) spr[bie_pkg::SP_IP] = bs + vb;
         bie_pkg::OP_JEQR_REG: if (fl == vc) spr[bie_pkg::SP_IP] = bs + vb;
         bie_pkg::OP_JNE_IMM: if (fl != {24'd0, w.arg_d}) spr[bie_pkg::SP_IP] = bs + tgt16;
         bie_pkg::OP_JNE_REG: if (fl != vd) spr[bie_pkg::SP_IP] = bs + tgt16;
         bie_pkg::OP_JNER_IMM: if (fl != imm16) spr[bie_pkg::SP_IP] = bs + vb;
         bie_pkg::OP_JNER_REG: if (fl != vc) spr[bie_pkg::SP_IP] = bs + vb;
         bie_pkg::OP_ADDI: wr_reg(w.arg_b, vb + imm16);
         bie_pkg::OP_ADD: wr_reg(w.arg_b, vb + rd_reg(w.arg_c));
         bie_pkg::OP_SUBI: begin
            spr[bie_pkg::SP_FLAGS] = cmp_flags(vb, imm16);
            vb = rd_reg(w.arg_b);
            wr_reg(w.arg_b, vb - imm16);
         end
         bie_pkg::OP_SUB: begin
            spr[bie_pkg::SP_FLAGS] = cmp_flags(vb, vc);
            vb = rd_reg(w.arg_b);
            vc = rd_reg(w.arg_c);
            wr_reg(w.arg_b, vb - vc);
         end
         bie_pkg::OP_MULI: wr_reg(w.arg_b, vb * imm16);
         bie_pkg::OP_MUL: wr_reg(w.arg_b, vb * vc);
         bie_pkg::OP_DIVI:
            if (imm16 == 0) r.status = bie_pkg::STAT_DIV0; else wr_reg(w.arg_b, vb / imm16);
         bie_pkg::OP_DIV:
            if (vc == 0) r.status = bie_pkg::STAT_DIV0; else wr_reg(w.arg_b, vb / vc);
         bie_pkg::OP_ANDI: wr_reg(w.arg_b, vb & imm16);
         bie_pkg::OP_AND: wr_reg(w.arg_b, vb & vc);
         bie_pkg::OP_ORI: wr_reg(w.arg_b, vb | imm16);
         bie_pkg::OP_OR: wr_reg(w.arg_b, vb | vc);
         bie_pkg::OP_XORI: wr_reg(w.arg_b, vb ^ imm16);
         bie_pkg::OP_XOR: wr_reg(w.arg_b, vb ^ vc);
         bie_pkg::OP_SHLI: wr_reg(w.arg_b, (imm16 >= 32) ? 32'd0 : vb << imm16);
         bie_pkg::OP_SHL: wr_reg(w.arg_b, (vc >= 32) ? 32'd0 : vb << vc);
         bie_pkg::OP_SHRI: wr_reg(w.arg_b, (imm16 >= 32) ? 32'd0 : vb >> imm16);
         bie_pkg::OP_SHR: wr_reg(w.arg_b, (vc >= 32) ? 32'd0 : vb >> vc);
         bie_pkg::OP_NOT: wr_reg(w.arg_b, ~vb);
         bie_pkg::OP_CMPI: spr[bie_pkg::SP_FLAGS] = cmp_flags(vb, imm16);
         bie_pkg::OP_CMP: spr[bie_pkg::SP_FLAGS] = cmp_flags(vb, vc);
         default: r.status = bie_pkg::STAT_INVALID;
      endcase
      if (r.status == bie_pkg::STAT_DIV0) n_div0++;
      if (w.opcode >= bie_pkg::OP_JEQ_IMM && w.opcode <= bie_pkg::OP_JNER_REG) n_jump++;
      if (svc) begin
         if (num == bie_pkg::SVC_EXIT_NUM && spr[bie_pkg::SP_SYS] == bie_pkg::SYS_EXIT) begin
            r.status = bie_pkg::STAT_END;
            r.exit_code = gpr[0];
         end else if (num == bie_pkg::SVC_EXIT_NUM
                      && spr[bie_pkg::SP_SYS] == bie_pkg::SYS_ABORT) begin
            r.status = bie_pkg::STAT_ABORT;
         end else begin
            r.service_request = 1;
            r.service_number = num;
            r.service_selector = spr[bie_pkg::SP_SYS];
            r.service_arg0 = gpr[0];
            r.service_arg1 = gpr[1];
            n_svc++;
         end
      end
      spr[bie_pkg::SP_IP] = spr[bie_pkg::SP_IP] + 32'd4;
      if (r.status == bie_pkg::STAT_RUN && spr[bie_pkg::SP_IP] >= end_addr)
         r.status = bie_pkg::STAT_END;
      r.next_ip = spr[bie_pkg::SP_IP];
      queue_result(r);
   endtask

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 0;
         req_if.opcode <= 0;
         req_if.arg_b <= 0;
         req_if.arg_c <= 0;
         req_if.arg_d <= 0;
         send_gap <= 0;
         n_sent <= 0;
      end else if (req_if.valid && !req_if.ready) begin
      end else begin
         if (req_if.valid) begin
            execute_word({req_if.opcode, req_if.arg_b, req_if.arg_c, req_if.arg_d});
            n_sent <= n_sent + 1;
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_if.valid <= 0;
         end else if (instr_q.size() > 0 && !pause_send) begin
            instr_type w;
            w = instr_q.pop_front();
            req_if.valid <= 1;
            {req_if.opcode, req_if.arg_b, req_if.arg_c, req_if.arg_d} <= w;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         end else begin
            req_if.valid <= 0;
         end
      end
   end

   // long receiver stall while the sender keeps offering words
   always @(posedge clock) begin
      if (reset) begin
         long_hold <= 0;
         hold_left <= 0;
         hold_used <= 0;
      end else if (!hold_used && n_sent >= 600) begin
         long_hold <= 1;
         hold_left <= 400;
         hold_used <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         if (hold_left == 1) long_hold <= 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 0;
         rsp_hold <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            result_type got, exp;
            got = {rsp_if.next_ip, rsp_if.status, rsp_if.exit_code,
                   rsp_if.service_request, rsp_if.service_number,
                   rsp_if.service_selector, rsp_if.service_arg0, rsp_if.service_arg1};
            if (result_q.size() == 0) begin
               $display("%0t unexpected result %h", $time, got);
               errors++;
            end else begin
               exp = result_q.pop_front();
               n_checked++;
               if (got.next_ip !== exp.next_ip)
                  $display("%0t next_ip exp %h got %h", $time, exp.next_ip, got.next_ip);
               if (got.status !== exp.status)
                  $display("%0t status exp %0d got %0d", $time, exp.status, got.status);
               if (got.exit_code !== exp.exit_code)
                  $display("%0t exit_code exp %h got %h", $time, exp.exit_code,
                           got.exit_code);
               if (got.service_request !== exp.service_request)
                  $display("%0t service_request exp %b got %b", $time,
                           exp.service_request, got.service_request);
               if (got.service_number !== exp.service_number)
                  $display("%0t service_number exp %h got %h", $time,
                           exp.service_number, got.service_number);
               if (got.service_selector !== exp.service_selector)
                  $display("%0t service_selector exp %h got %h", $time,
                           exp.service_selector, got.service_selector);
               if (got.service_arg0 !== exp.service_arg0)
                  $display("%0t service_arg0 exp %h got %h", $time,
                           exp.service_arg0, got.service_arg0);
               if (got.service_arg1 !== exp.service_arg1)
                  $display("%0t service_arg1 exp %h got %h", $time,
                           exp.service_arg1, got.service_arg1);
               if (got !== exp) errors++;
            end
         end
         if (long_hold) begin
            rsp_if.ready <= 0;
         end else if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_if.ready <= 0;
         end else if (!rsp_if.ready || rsp_if.valid) begin
            rsp_if.ready <= 1;
            rsp_hold <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3_000_000) begin
         $display("timeout");
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_write(input logic [7:0] idx, input logic [31:0] v);
      csr_if.valid <= 1;
      csr_if.index <= idx;
      csr_if.data <= v;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (idx == bie_pkg::CSR_CODE_BASE) base_cfg = v; else len_cfg = v;
      load_code();
      csr_if.valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (instr_q.size() > 0 || req_if.valid || result_q.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [7:0] rnd_reg();
      int k;
      k = $urandom_range(0, 19);
      if (k < 12) return 8'($urandom_range(0, NGR - 1));
      if (k < 18) return 8'($urandom_range(NGR, NGR + NSP - 1));
      return 8'($urandom_range(NGR + NSP, 255));
   endfunction

   function automatic instr_type rnd_instr();
      instr_type w;
      int k;
      k = $urandom_range(0, 99);
      w.arg_b = rnd_reg();
      w.arg_c = ($urandom_range(0, 1)) ? rnd_reg() : 8'($urandom);
      w.arg_d = ($urandom_range(0, 1)) ? rnd_reg() : 8'($urandom);
      if (k < 4) w.opcode = 8'($urandom_range(int'(bie_pkg::OP_CMP) + 1, 255));
      else w.opcode = 8'($urandom_range(int'(bie_pkg::OP_NOP), int'(bie_pkg::OP_CMP)));
      // keep jumps inside the segment most of the time
      if (w.opcode >= bie_pkg::OP_JEQ_IMM && w.opcode <= bie_pkg::OP_JNER_REG
          && $urandom_range(0, 3) != 0)
         w.arg_b = 0;
      // set up system flags for exits and aborts
      if (k >= 4 && k < 8) begin
         w.opcode = bie_pkg::OP_LDI;
         w.arg_b = 8'(NGR + bie_pkg::SP_SYS);
         w.arg_c = 0;
         w.arg_d = 8'($urandom_range(0, 3));
      end
      if (k >= 8 && k < 10) begin
         w.opcode = bie_pkg::OP_SVCI;
         w.arg_b = 0;
         w.arg_c = 0;
         w.arg_d = 8'($urandom_range(0, 2));
      end
      if (k >= 10 && k < 14) begin
         w.opcode = bie_pkg::OP_LDI;
         w.arg_b = 8'(NGR + bie_pkg::SP_ADDR);
      end
      return w;
   endfunction

   initial begin
      logic [31:0] bases [4];
      logic [31:0] lens [4];
      reset = 1;
      csr_if.valid = 0;
      csr_if.index = 0;
      csr_if.data = 0;
      base_cfg = 0;
      len_cfg = 0;
      foreach (gpr[i]) gpr[i] = 0;
      foreach (spr[i]) spr[i] = 0;
      foreach (dmem[i]) dmem[i] = 0;
      scratch = 0;
      spare = 0;
      load_code();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // length zero: every word ends immediately
      queue_word({bie_pkg::OP_NOP, 8'h00, 8'h00, 8'h00});
      drain();

      csr_write(bie_pkg::CSR_CODE_BASE, 32'h0000_1000);
      csr_write(bie_pkg::CSR_CODE_LENGTH, 32'h0001_0000);
      queue_word({bie_pkg::OP_LDI, 8'd0, 8'hFF, 8'hFF});
      queue_word({bie_pkg::OP_LDI, 8'd1, 8'h00, 8'h00});
      queue_word({bie_pkg::OP_NOT, 8'd1, 8'h00, 8'h00});
      queue_word({bie_pkg::OP_ADD, 8'd0, 8'd1, 8'h00});
      queue_word({bie_pkg::OP_MULI, 8'd1, 8'hFF, 8'hFF});
      queue_word({bie_pkg::OP_DIVI, 8'd1, 8'h00, 8'h00});
      queue_word({bie_pkg::OP_DIV, 8'd1, 8'd2, 8'h00});
      queue_word({bie_pkg::OP_DIV, 8'd1, 8'd0, 8'h00});
      queue_word({bie_pkg::OP_SHLI, 8'd1, 8'h00, 8'd32});
      queue_word({bie_pkg::OP_SHRI, 8'd0, 8'h00, 8'd31});
      queue_word({bie_pkg::OP_LDI, 8'd200, 8'hAB, 8'hCD});
      queue_word({bie_pkg::OP_MOV, 8'd3, 8'd255, 8'h00});
      queue_word({bie_pkg::OP_LDI, 8'(NGR + bie_pkg::SP_ADDR), 8'hFF, 8'hFF});
      queue_word({bie_pkg::OP_STI, 8'h5A, 8'h00, 8'h00});
      queue_word({bie_pkg::OP_LD, 8'd4, 8'h00, 8'h00});
      queue_word({bie_pkg::OP_MOV, 8'(NGR + bie_pkg::SP_ADDR), 8'd1, 8'h00});
      queue_word({bie_pkg::OP_ST, 8'd3, 8'h00, 8'h00});
      queue_word({bie_pkg::OP_LD, 8'd5, 8'h00, 8'h00});
      queue_word({bie_pkg::OP_CMPI, 8'd5, 8'h00, 8'hCD});
      queue_word({bie_pkg::OP_JEQ_IMM, 8'h00, 8'h40, 8'h02});
      queue_word({bie_pkg::OP_SUBI, 8'd5, 8'hFF, 8'hFF});
      queue_word({bie_pkg::OP_SUBI, 8'(NGR + bie_pkg::SP_FLAGS), 8'h00, 8'h01});
      queue_word({bie_pkg::OP_JNE_REG, 8'h00, 8'h10, 8'd6});
      queue_word({bie_pkg::OP_LDI, 8'(NGR + bie_pkg::SP_SYS), 8'h00, 8'h01});
      queue_word({bie_pkg::OP_SVCI, 8'h00, 8'h00, 8'h01});
      queue_word({8'hFF, 8'hFF, 8'hFF, 8'hFF});
      queue_word({bie_pkg::OP_LDI, 8'(NGR + bie_pkg::SP_SYS), 8'h00, 8'h02});
      queue_word({bie_pkg::OP_SVC, 8'd7, 8'h00, 8'h00});
      drain();

      bases = '{32'h0, 32'hFFFF_FFF0, 32'h0000_8000, 32'h1234_5678};
      lens = '{32'hFFFF_FFFF, 32'h0000_0100, 32'h0000_0040, 32'h0010_0000};
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(bie_pkg::CSR_CODE_BASE, bases[ph % 4]);
         csr_write(bie_pkg::CSR_CODE_LENGTH, lens[(ph + ph / 4) % 4]);
         for (int i = 0; i < 210; i++) queue_word(rnd_instr());
         if (ph == 5) begin
            while (instr_q.size() > 100) @(posedge clock);
            pause_send = 1;
            while (req_if.valid || result_q.size() > 0) @(posedge clock);
            pause_send = 0;
         end
         drain();
      end

      $display("checked %0d results: %0d service requests, %0d jumps, %0d divide by zero",
               n_checked, n_svc, n_jump, n_div0);
      $display("eight code segment settings, including a wrapping end and full length");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
